@@ design/spi_flash_command_sequencer_top_defines.svh @@
// assertion macros used by the checker file of the flash command sequencer
// depends on nothing; each macro expands to one labeled concurrent assertion
`ifndef SPI_FLASH_COMMAND_SEQUENCER_TOP_DEFINES_SVH
`define SPI_FLASH_COMMAND_SEQUENCER_TOP_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define SPIFCS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition that must never be seen outside reset
`define SPIFCS_NEVER(label, cond, msg) \
   `SPIFCS_ASSERT(label, !(cond), msg)

`endif

@@ design/spifcs_pkg.sv @@
// types, codes and the link action sequence table of the flash command sequencer
// depends on nothing; used by the front, queue, back, top and checker files
package spifcs_pkg;

   // result kinds
   typedef enum logic [2:0] {
      K_SEL_LOW  = 3'd0,
      K_SEL_HIGH = 3'd1,
      K_SEND     = 3'd2,
      K_FETCH    = 3'd3,
      K_DONE     = 3'd4
   } kind_type;

   // input actions
   localparam logic [2:0] ACT_READ     = 3'd0;
   localparam logic [2:0] ACT_PROGRAM  = 3'd1;
   localparam logic [2:0] ACT_ERASE    = 3'd2;
   localparam logic [2:0] ACT_IDENTIFY = 3'd3;
   localparam logic [2:0] ACT_RX_BYTE  = 3'd4;

   // register indexes
   localparam logic [2:0] REG_KNOWN_ID_0 = 3'd0;
   localparam logic [2:0] REG_IDLE_POLLS = 3'd4;
   localparam int unsigned NUM_KNOWN_IDS = 4;

   localparam logic [23:0] KNOWN_ID_RESET [NUM_KNOWN_IDS] = '{
      24'd12722194, 24'd12722197, 24'd12723511, 24'd12723512
   };
   localparam logic [3:0] IDLE_POLLS_RESET = 4'd3;
   localparam logic [3:0] POLL_COUNT_MAX   = 4'd15;

   // flash command bytes
   localparam logic [7:0] CMD_WREN  = 8'h06;
   localparam logic [7:0] CMD_PP    = 8'h02;
   localparam logic [7:0] CMD_RDSR  = 8'h05;
   localparam logic [7:0] CMD_WRDI  = 8'h04;
   localparam logic [7:0] CMD_READ  = 8'h03;
   localparam logic [7:0] CMD_RDID  = 8'h9F;
   localparam logic [7:0] CMD_SE    = 8'h20;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_READ,
      PH_ID,
      PH_ARM,
      PH_POLL
   } phase_type;

   // work handed from front to back
   typedef enum logic [2:0] {
      JOB_READ,
      JOB_PROG,
      JOB_ERASE,
      JOB_IDENT,
      JOB_FETCH,
      JOB_READ_DONE,
      JOB_ID_DONE,
      JOB_POLL_DONE
   } job_type;

   typedef struct packed {
      job_type     job;
      logic [23:0] address;
      logic [7:0]  data;
      logic        found;
      logic [1:0]  entry;
   } job_entry_type;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned STEP_W      = 4;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic        wen;
      logic [2:0]  index;
      logic [23:0] wdata;
   } csr_write_type;

   // where the byte of one link action comes from
   typedef enum logic [2:0] {
      SRC_NONE,
      SRC_CONST,
      SRC_ADDR_HI,
      SRC_ADDR_MID,
      SRC_ADDR_LO,
      SRC_DATA,
      SRC_RESULT
   } src_type;

   typedef struct packed {
      kind_type   kind;
      src_type    src;
      logic [7:0] cbyte;
      logic       fin;
   } step_type;

   function automatic step_type mk(kind_type kind, src_type src, logic [7:0] cbyte,
                                   logic fin);
      step_type s;
      s.kind  = kind;
      s.src   = src;
      s.cbyte = cbyte;
      s.fin   = fin;
      return s;
   endfunction

   localparam step_type ST_SL    = '{K_SEL_LOW,  SRC_NONE, 8'h00, 1'b0};
   localparam step_type ST_SH    = '{K_SEL_HIGH, SRC_NONE, 8'h00, 1'b0};
   localparam step_type ST_A2    = '{K_SEND, SRC_ADDR_HI,  8'h00, 1'b0};
   localparam step_type ST_A1    = '{K_SEND, SRC_ADDR_MID, 8'h00, 1'b0};
   localparam step_type ST_A0    = '{K_SEND, SRC_ADDR_LO,  8'h00, 1'b0};
   localparam step_type ST_FETCH = '{K_FETCH, SRC_NONE, 8'h00, 1'b1};

   // link action for one step of one job
   function automatic step_type step_info(job_type job, logic [STEP_W-1:0] step);
      step_type s;
      s = mk(K_DONE, SRC_NONE, 8'h00, 1'b1);
      unique case (job)
         JOB_READ: begin
            unique case (step)
               4'd0: s = ST_SL;
               4'd1: s = mk(K_SEND, SRC_CONST, CMD_READ, 1'b0);
               4'd2: s = ST_A2;
               4'd3: s = ST_A1;
               4'd4: s = ST_A0;
               default: s = ST_FETCH;
            endcase
         end
         JOB_PROG: begin
            unique case (step)
               4'd0: s = ST_SL;
               4'd1: s = mk(K_SEND, SRC_CONST, CMD_WREN, 1'b0);
               4'd2: s = ST_SH;
               4'd3: s = ST_SL;
               4'd4: s = mk(K_SEND, SRC_CONST, CMD_PP, 1'b0);
               4'd5: s = ST_A2;
               4'd6: s = ST_A1;
               4'd7: s = ST_A0;
               4'd8: s = mk(K_SEND, SRC_DATA, 8'h00, 1'b0);
               4'd9: s = ST_SH;
               4'd10: s = ST_SL;
               default: s = mk(K_SEND, SRC_CONST, CMD_RDSR, 1'b1);
            endcase
         end
         JOB_ERASE: begin
            unique case (step)
               4'd0: s = ST_SL;
               4'd1: s = mk(K_SEND, SRC_CONST, CMD_WREN, 1'b0);
               4'd2: s = ST_SH;
               4'd3: s = ST_SL;
               4'd4: s = mk(K_SEND, SRC_CONST, CMD_SE, 1'b0);
               4'd5: s = ST_A2;
               4'd6: s = ST_A1;
               4'd7: s = ST_A0;
               4'd8: s = ST_SH;
               4'd9: s = ST_SL;
               4'd10: s = mk(K_SEND, SRC_CONST, CMD_RDSR, 1'b0);
               default: s = ST_FETCH;
            endcase
         end
         JOB_IDENT: begin
            unique case (step)
               4'd0: s = ST_SL;
               4'd1: s = mk(K_SEND, SRC_CONST, CMD_RDID, 1'b0);
               default: s = ST_FETCH;
            endcase
         end
         JOB_FETCH: s = ST_FETCH;
         JOB_READ_DONE, JOB_ID_DONE: begin
            unique case (step)
               4'd0: s = ST_SH;
               default: s = mk(K_DONE, SRC_RESULT, 8'h00, 1'b1);
            endcase
         end
         JOB_POLL_DONE: begin
            unique case (step)
               4'd0: s = ST_SH;
               4'd1: s = ST_SL;
               4'd2: s = mk(K_SEND, SRC_CONST, CMD_WRDI, 1'b0);
               4'd3: s = ST_SH;
               default: s = mk(K_DONE, SRC_NONE, 8'h00, 1'b1);
            endcase
         end
         default: s = mk(K_DONE, SRC_NONE, 8'h00, 1'b1);
      endcase
      return s;
   endfunction

endpackage

@@ design/spifcs_front.sv @@
// front of the flash command sequencer: takes request items, tracks the phase and
// the config registers, and turns each expected item into a job; uses spifcs_pkg
module spifcs_front #(
   parameter int unsigned ID_ENTRIES = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  spifcs_pkg::csr_write_type csr,
   input  logic                    item_valid,
   input  logic [2:0]              action,
   input  logic [23:0]             address,
   input  logic [7:0]              write_data,
   input  logic [7:0]              received_byte,
   input  spifcs_pkg::queue_status_type qstat,
   output logic                    item_ready,
   output logic                    push,
   output spifcs_pkg::job_entry_type push_entry
);
   import spifcs_pkg::*;

   localparam int unsigned STORED_IDS =
      (ID_ENTRIES < NUM_KNOWN_IDS) ? ID_ENTRIES : NUM_KNOWN_IDS;

   logic [23:0] known_id_ff [STORED_IDS];
   logic [3:0]  idle_polls_ff;

   phase_type   phase_ff, phase_in;
   logic [3:0]  poll_cnt_ff, poll_cnt_in;
   logic [1:0]  id_cnt_ff, id_cnt_in;
   logic [7:0]  id_hi_ff, id_hi_in;
   logic [7:0]  id_lo_ff, id_lo_in;

   logic        accept;
   logic [3:0]  poll_inc;
   logic [3:0]  poll_need;
   logic        poll_hit;
   logic [23:0] id_full;
   logic        id_found;
   logic [1:0]  id_entry;

   assign item_ready = !qstat.full;
   assign accept     = item_valid && item_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STORED_IDS; i++) begin
            known_id_ff[i] <= KNOWN_ID_RESET[i];
         end
         idle_polls_ff <= IDLE_POLLS_RESET;
      end else if (csr.wen) begin
         for (int i = 0; i < STORED_IDS; i++) begin
            if (csr.index == 3'(REG_KNOWN_ID_0 + i)) begin
               known_id_ff[i] <= csr.wdata;
            end
         end
         if (csr.index == REG_IDLE_POLLS) begin
            idle_polls_ff <= csr.wdata[3:0];
         end
      end
   end

   // clear status reads counted with saturation, target of zero acts as one
   assign poll_inc  = (poll_cnt_ff == POLL_COUNT_MAX) ? poll_cnt_ff : poll_cnt_ff + 4'd1;
   assign poll_need = (idle_polls_ff == 4'd0) ? 4'd1 : idle_polls_ff;
   assign poll_hit  = !received_byte[0] && (poll_inc >= poll_need);

   assign id_full = {id_hi_ff, id_lo_ff, received_byte};

   // descending so the lowest matching entry wins
   always_comb begin
      id_found = 1'b0;
      id_entry = 2'd0;
      for (int i = STORED_IDS - 1; i >= 0; i--) begin
         if (known_id_ff[i] == id_full) begin
            id_found = 1'b1;
            id_entry = 2'(i);
         end
      end
   end

   // next state
   always_comb begin
      phase_in    = phase_ff;
      poll_cnt_in = poll_cnt_ff;
      id_cnt_in   = id_cnt_ff;
      id_hi_in    = id_hi_ff;
      id_lo_in    = id_lo_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (action == ACT_READ) begin
                  phase_in = PH_READ;
               end else if (action == ACT_PROGRAM) begin
                  phase_in    = PH_ARM;
                  poll_cnt_in = 4'd0;
               end else if (action == ACT_ERASE) begin
                  phase_in    = PH_POLL;
                  poll_cnt_in = 4'd0;
               end else if (action == ACT_IDENTIFY) begin
                  phase_in  = PH_ID;
                  id_cnt_in = 2'd0;
               end
            end
            PH_ARM: phase_in = PH_POLL;
            PH_READ: begin
               if (action == ACT_RX_BYTE) begin
                  phase_in = PH_IDLE;
               end
            end
            PH_ID: begin
               if (action == ACT_RX_BYTE) begin
                  if (id_cnt_ff == 2'd0) begin
                     id_hi_in  = received_byte;
                     id_cnt_in = 2'd1;
                  end else if (id_cnt_ff == 2'd1) begin
                     id_lo_in  = received_byte;
                     id_cnt_in = 2'd2;
                  end else begin
                     id_cnt_in = 2'd0;
                     phase_in  = PH_IDLE;
                  end
               end
            end
            PH_POLL: begin
               if (action == ACT_RX_BYTE) begin
                  if (received_byte[0]) begin
                     poll_cnt_in = 4'd0;
                  end else if (poll_hit) begin
                     poll_cnt_in = 4'd0;
                     phase_in    = PH_IDLE;
                  end else begin
                     poll_cnt_in = poll_inc;
                  end
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   // job for the accepted item
   always_comb begin
      push               = 1'b0;
      push_entry.job     = JOB_FETCH;
      push_entry.address = address;
      push_entry.data    = write_data;
      push_entry.found   = 1'b0;
      push_entry.entry   = 2'd0;
      if (accept) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (action == ACT_READ) begin
                  push           = 1'b1;
                  push_entry.job = JOB_READ;
               end else if (action == ACT_PROGRAM) begin
                  push           = 1'b1;
                  push_entry.job = JOB_PROG;
               end else if (action == ACT_ERASE) begin
                  push           = 1'b1;
                  push_entry.job = JOB_ERASE;
               end else if (action == ACT_IDENTIFY) begin
                  push           = 1'b1;
                  push_entry.job = JOB_IDENT;
               end
            end
            PH_ARM: push = 1'b1;
            PH_READ: begin
               if (action == ACT_RX_BYTE) begin
                  push            = 1'b1;
                  push_entry.job  = JOB_READ_DONE;
                  push_entry.data = received_byte;
               end
            end
            PH_ID: begin
               if (action == ACT_RX_BYTE) begin
                  push = 1'b1;
                  if (id_cnt_ff != 2'd0 && id_cnt_ff != 2'd1) begin
                     push_entry.job   = JOB_ID_DONE;
                     push_entry.found = id_found;
                     push_entry.entry = id_entry;
                  end
               end
            end
            PH_POLL: begin
               if (action == ACT_RX_BYTE) begin
                  push = 1'b1;
                  if (poll_hit) begin
                     push_entry.job = JOB_POLL_DONE;
                  end
               end
            end
            default: push = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         poll_cnt_ff <= 4'd0;
         id_cnt_ff   <= 2'd0;
      end else begin
         phase_ff    <= phase_in;
         poll_cnt_ff <= poll_cnt_in;
         id_cnt_ff   <= id_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      id_hi_ff <= id_hi_in;
      id_lo_ff <= id_lo_in;
   end

endmodule

@@ design/spifcs_queue.sv @@
// short job queue between front and back of the flash command sequencer
// depends on spifcs_pkg for the entry type and depth
module spifcs_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  spifcs_pkg::job_entry_type    push_entry,
   input  logic                         pop,
   output spifcs_pkg::job_entry_type    head,
   output spifcs_pkg::queue_status_type status
);
   import spifcs_pkg::*;

   job_entry_type     slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign status.full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head         = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ design/spifcs_back.sv @@
// back of the flash command sequencer: steps through the link actions of the
// job at the queue head into a registered result stage; uses spifcs_pkg
module spifcs_back (
   input  logic                         clock,
   input  logic                         reset,
   input  spifcs_pkg::job_entry_type    head,
   input  spifcs_pkg::queue_status_type qstat,
   output logic                         pop,
   output logic                         out_valid,
   input  logic                         out_ready,
   output spifcs_pkg::kind_type         kind,
   output logic [7:0]                   send_byte,
   output logic [7:0]                   read_data,
   output logic                         id_found,
   output logic [1:0]                   id_entry,
   output logic                         last
);
   import spifcs_pkg::*;

   logic [STEP_W-1:0] step_ff, step_in;
   logic              valid_ff, valid_in;
   kind_type          kind_ff;
   logic [7:0]        send_ff, send_in;
   logic [7:0]        rdata_ff, rdata_in;
   logic              found_ff, found_in;
   logic [1:0]        entry_ff, entry_in;
   logic              last_ff;

   step_type          info;
   logic              load;
   logic              fire;

   assign info = step_info(head.job, step_ff);
   assign load = !valid_ff || out_ready;
   assign fire = load && !qstat.empty;
   assign pop  = fire && info.fin;

   always_comb begin
      step_in  = step_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = !qstat.empty;
      end
      if (fire) begin
         step_in = info.fin ? '0 : step_ff + 1'b1;
      end
   end

   always_comb begin
      send_in  = 8'h00;
      rdata_in = 8'h00;
      found_in = 1'b0;
      entry_in = 2'd0;
      unique case (info.src)
         SRC_CONST:    send_in = info.cbyte;
         SRC_ADDR_HI:  send_in = head.address[23:16];
         SRC_ADDR_MID: send_in = head.address[15:8];
         SRC_ADDR_LO:  send_in = head.address[7:0];
         SRC_DATA:     send_in = head.data;
         SRC_RESULT: begin
            rdata_in = (head.job == JOB_READ_DONE) ? head.data : 8'h00;
            found_in = head.found;
            entry_in = head.entry;
         end
         default: send_in = 8'h00;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         kind_ff  <= info.kind;
         send_ff  <= send_in;
         rdata_ff <= rdata_in;
         found_ff <= found_in;
         entry_ff <= entry_in;
         last_ff  <= info.fin;
      end
   end

   assign out_valid = valid_ff;
   assign kind      = kind_ff;
   assign send_byte = send_ff;
   assign read_data = rdata_ff;
   assign id_found  = found_ff;
   assign id_entry  = entry_ff;
   assign last      = last_ff;

endmodule

@@ design/spi_flash_command_sequencer_top.sv @@
// SPI NOR flash command sequencer. Each request item is classified at once by the
// front and, if its phase expects it, becomes a job in a four-entry queue; the
// back emits that job's link actions one result per cycle while the output is not
// stalled, so a read gives 6 results, program and erase 12, identify 3, and a
// received byte 1, 2 or 5. The front takes one item per cycle while the queue has
// room, and the sustained rate is set by the back's step counter.
// There is no clearing pass after reset. Reset is synchronous and active high.
// Depends on spifcs_pkg, spifcs_front, spifcs_queue and spifcs_back.
module spi_flash_command_sequencer_top #(
   parameter int unsigned ID_ENTRIES = 4
) (
   input  logic        clock,
   input  logic        reset,
   // configuration writes
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata,
   // request items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // address[23:0], write_data[31:24], received_byte[39:32]
   input  logic [2:0]  req_tuser,   // action[2:0]
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // send_byte[7:0], read_data[15:8], id_found[16],
                                    // id_entry[18:17], zero[23:19]
   output logic [2:0]  rsp_tuser,   // kind[2:0]
   output logic        rsp_tlast    // last
);
   import spifcs_pkg::*;

   csr_write_type    csr;
   queue_status_type qstat;
   job_entry_type    push_entry;
   job_entry_type    head;
   logic             push;
   logic             pop;
   kind_type         kind;
   logic [7:0]       send_byte;
   logic [7:0]       read_data;
   logic             id_found;
   logic [1:0]       id_entry;

   assign csr.wen   = csr_wen;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   spifcs_front #(
      .ID_ENTRIES (ID_ENTRIES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr           (csr),
      .item_valid    (req_tvalid),
      .action        (req_tuser),
      .address       (req_tdata[23:0]),
      .write_data    (req_tdata[31:24]),
      .received_byte (req_tdata[39:32]),
      .qstat         (qstat),
      .item_ready    (req_tready),
      .push          (push),
      .push_entry    (push_entry)
   );

   spifcs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (qstat)
   );

   spifcs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .qstat     (qstat),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .kind      (kind),
      .send_byte (send_byte),
      .read_data (read_data),
      .id_found  (id_found),
      .id_entry  (id_entry),
      .last      (rsp_tlast)
   );

   assign rsp_tuser = kind;
   assign rsp_tdata = {5'b00000, id_entry, id_found, read_data, send_byte};

endmodule

@@ design/spifcs_checker.sv @@
// port level checks of the flash command sequencer, bound to the top level
// depends on spifcs_pkg and the assertion macros header
`include "spi_flash_command_sequencer_top_defines.svh"

module spifcs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import spifcs_pkg::*;

   logic        is_send;
   logic        is_done;
   logic        stalled;
   logic [27:0] rsp_bundle;
   logic        byte_set;
   logic        done_set;

   assign is_send    = (rsp_tuser == K_SEND);
   assign is_done    = (rsp_tuser == K_DONE);
   assign stalled    = rsp_tvalid && !rsp_tready;
   assign rsp_bundle = {rsp_tlast, rsp_tuser, rsp_tdata};
   assign byte_set   = (rsp_tdata[7:0] != 8'h00);
   assign done_set   = (rsp_tdata[18:8] != 11'd0);

   // a stalled result keeps its contents
   `SPIFCS_ASSERT(a_rsp_hold, stalled |=> rsp_tvalid && $stable(rsp_bundle), "result changed")
   // only send actions carry a byte
   `SPIFCS_NEVER(a_byte_only_on_send, rsp_tvalid && !is_send && byte_set, "stray send byte")
   // read data and id fields only on done
   `SPIFCS_NEVER(a_fields_only_on_done, rsp_tvalid && !is_done && done_set, "stray done fields")
   // done always closes the item's results
   `SPIFCS_ASSERT(a_done_is_last, rsp_tvalid && is_done |-> rsp_tlast, "done without last")

endmodule

bind spi_flash_command_sequencer_top spifcs_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
